### rtl/assert_macros.svh
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cbtp_pkg.sv
// ----------------------------------------------------------------------------
// cbtp_pkg
// Types, constants and fixed-point helpers of the transmit probability
// controller.
// ----------------------------------------------------------------------------
package cbtp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_USERS = 64;
    localparam int PW        = FRAC_BITS + 1;            // probability width
    localparam int NW        = $clog2(MAX_USERS + 1);    // user count width
    localparam int AW        = 64;                       // multiplicand width
    localparam int BW        = 32;                       // multiplier width

    localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;
    localparam logic signed [AW-1:0] ONE_W = AW'(1) << FRAC_BITS;
    localparam logic signed [AW-1:0] GRAD_LIM = AW'(1) << 38;

    // configuration register indexes
    localparam logic [3:0] REG_BUDGET    = 4'd0;
    localparam logic [3:0] REG_GRAD_GAIN = 4'd1;
    localparam logic [3:0] REG_MULT_GAIN = 4'd2;
    localparam logic [3:0] REG_MAX_STEP  = 4'd3;
    localparam logic [3:0] REG_MIN_PROB  = 4'd4;
    localparam logic [3:0] REG_MAX_PROB  = 4'd5;
    localparam logic [3:0] REG_Q_FLOOR   = 4'd6;
    localparam logic [3:0] REG_DEF_PROB  = 4'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_POW, S_NP, S_SUCC, S_DS1, S_DS2, S_DC1, S_DC2, S_DC3,
        S_GRAD, S_MH, S_ML, S_DEL, S_MU, S_WB
    } t_state;

    // request to the serial multiplier
    typedef struct packed {
        logic                 start;
        logic signed [AW-1:0] a;
        logic [BW-1:0]        b;
    } t_mul_req;

    // shift right by FRAC_BITS, round to nearest, ties away from zero
    function automatic logic signed [AW-1:0] rnd_shift(input logic signed [AW-1:0] v);
        logic [AW-1:0] m;
        logic [AW-1:0] half;
        begin
            half = AW'(1) << (FRAC_BITS - 1);
            if (v < 0) begin
                m = AW'(-v);
                rnd_shift = -$signed((m + half) >> FRAC_BITS);
            end else begin
                rnd_shift = $signed((AW'(v) + half) >> FRAC_BITS);
            end
        end
    endfunction

    // gradient saturation to +-2^38
    function automatic logic signed [39:0] sat_grad(input logic signed [AW-1:0] v);
        begin
            if (v > GRAD_LIM) sat_grad = GRAD_LIM[39:0];
            else if (v < -GRAD_LIM) sat_grad = 40'(-GRAD_LIM);
            else sat_grad = v[39:0];
        end
    endfunction

endpackage

### rtl/cbtp_smul.sv
// ----------------------------------------------------------------------------
// cbtp_smul
// Bit-serial shift-add multiplier: one multiplier bit per cycle, stops early
// once the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module cbtp_smul
    import cbtp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mul_req             i_req,
    output logic                 o_done,
    output logic signed [AW-1:0] o_prod
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic signed [AW-1:0] r_acc, n_acc;
    logic signed [AW-1:0] r_a, n_a;
    logic [BW-1:0]        r_b, n_b;

    // one partial product per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_acc  = '0;
            n_a    = i_req.a;
            n_b    = i_req.b;
        end else if (r_busy) begin
            if (r_b == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                if (r_b[0]) n_acc = r_acc + r_a;
                n_a = r_a <<< 1;
                n_b = r_b >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### rtl/collision_budget_tx_prob_controller_top.sv
// Sequence per item: n power steps on the bit-serial multiplier (n = ready
//   users), then up to eleven products; small operands finish early.
// Throughput: one item at a time; the next item is taken once the result is
//   in the output register. Reset: synchronous active low, registers to
//   their defaults, multiplier state to zero, no pending result.
// ----------------------------------------------------------------------------
// collision_budget_tx_prob_controller_top
// Slotted-ALOHA transmit probability controller with a collision budget and
// a Lagrange multiplier, all products through one serial multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module collision_budget_tx_prob_controller_top
    import cbtp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // current_prob[16:0], ready_users[23:17]
    input  logic [0:0]  i_s_axis_tuser,   // has_plan[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // new_prob[16:0], multiplier_out[48:17],
                                          // collision_rate[65:49], zero[71:66]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    t_state r_state, n_state;

    // configuration
    logic [PW-1:0] r_budget, r_max_step, r_min_prob, r_max_prob, r_q_floor, r_def_prob;
    logic [23:0]   r_grad_gain, r_mult_gain;

    // item registers
    logic [PW-1:0]        r_p, r_q, r_pw, r_qn, r_qn1, r_qn2;
    logic [NW-1:0]        r_n, r_k;
    logic [22:0]          r_np_raw;
    logic [PW-1:0]        r_coll;
    logic signed [17:0]   r_gap;
    logic signed [31:0]   r_ds;
    logic [31:0]          r_dc;
    logic signed [AW-1:0] r_t;
    logic signed [39:0]   r_grad;
    logic [PW-1:0]        r_newp;
    logic [31:0]          r_mu, r_lagrange;
    logic                 r_issued, n_issued;
    logic                 r_o_valid;
    logic [71:0]          r_o_data;

    t_mul_req             w_req;
    logic                 w_done;
    logic signed [AW-1:0] w_prod, w_rnd;
    logic                 w_mul_state;

    cbtp_smul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_prod  (w_prod)
    );

    assign w_rnd = rnd_shift(w_prod);

    // input field decode
    logic [PW-1:0] w_sel, w_p, w_qr, w_qf, w_q;
    logic [NW-1:0] w_n;
    always_comb begin
        w_sel = i_s_axis_tuser[0] ? i_s_axis_tdata[16:0] : r_def_prob;
        w_p   = (w_sel > ONE) ? ONE : w_sel;
        w_qr  = ONE - w_p;
        w_qf  = (w_qr < r_q_floor) ? r_q_floor : w_qr;
        w_q   = (w_qf > ONE) ? ONE : w_qf;
        if (i_s_axis_tdata[23:17] == 7'd0) w_n = NW'(1);
        else if (i_s_axis_tdata[23:17] > 7'(MAX_USERS)) w_n = NW'(MAX_USERS);
        else w_n = NW'(i_s_axis_tdata[23:17]);
    end

    // configuration port
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget    <= 17'd6554;
            r_grad_gain <= 24'd655;
            r_mult_gain <= 24'd6554;
            r_max_step  <= 17'd3277;
            r_min_prob  <= 17'd66;
            r_max_prob  <= 17'd65536;
            r_q_floor   <= 17'd1;
            r_def_prob  <= 17'd6554;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BUDGET:    r_budget    <= i_cfg_data[16:0];
                REG_GRAD_GAIN: r_grad_gain <= i_cfg_data;
                REG_MULT_GAIN: r_mult_gain <= i_cfg_data;
                REG_MAX_STEP:  r_max_step  <= i_cfg_data[16:0];
                REG_MIN_PROB:  r_min_prob  <= i_cfg_data[16:0];
                REG_MAX_PROB:  r_max_prob  <= i_cfg_data[16:0];
                REG_Q_FLOOR:   r_q_floor   <= i_cfg_data[16:0];
                REG_DEF_PROB:  r_def_prob  <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_s_axis_tvalid) n_state = S_POW;
            S_POW:  if (!r_issued && r_k == r_n) n_state = S_NP;
            S_NP:   if (w_done) n_state = S_SUCC;
            S_SUCC: if (w_done) n_state = (r_n == NW'(1)) ? S_GRAD : S_DS1;
            S_DS1:  if (w_done) n_state = S_DS2;
            S_DS2:  if (w_done) n_state = S_DC1;
            S_DC1:  if (w_done) n_state = S_DC2;
            S_DC2:  if (w_done) n_state = S_DC3;
            S_DC3:  if (w_done) n_state = S_GRAD;
            S_GRAD: n_state = (r_gap > 0) ? S_MH : S_DEL;
            S_MH:   if (w_done) n_state = S_ML;
            S_ML:   if (w_done) n_state = S_DEL;
            S_DEL:  if (w_done) n_state = S_MU;
            S_MU:   if (w_done) n_state = S_WB;
            S_WB:   if (!r_o_valid || i_m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: multiplier requests and input ready
    always_comb begin
        w_mul_state = 1'b1;
        w_req.a     = '0;
        w_req.b     = '0;
        case (r_state)
            S_POW:  begin w_req.a = AW'(r_pw);     w_req.b = BW'(r_q);   end
            S_NP:   begin w_req.a = AW'(r_p);      w_req.b = BW'(r_n);   end
            S_SUCC: begin w_req.a = AW'(r_np_raw); w_req.b = BW'(r_qn1); end
            S_DS1:  begin w_req.a = ONE_W - AW'(r_np_raw); w_req.b = BW'(r_qn2); end
            S_DS2:  begin w_req.a = r_t;           w_req.b = BW'(r_n);   end
            S_DC1:  begin w_req.a = AW'(r_p);      w_req.b = BW'(r_qn2); end
            S_DC2:  begin w_req.a = r_t;           w_req.b = BW'(r_n);   end
            S_DC3:  begin w_req.a = r_t;           w_req.b = BW'(r_n - NW'(1)); end
            S_MH:   begin w_req.a = AW'(r_lagrange); w_req.b = BW'(r_dc[31:FRAC_BITS]); end
            S_ML:   begin w_req.a = AW'(r_lagrange); w_req.b = BW'(r_dc[FRAC_BITS-1:0]); end
            S_DEL:  begin w_req.a = AW'(r_grad);   w_req.b = BW'(r_grad_gain); end
            S_MU:   begin w_req.a = AW'(r_gap);    w_req.b = BW'(r_mult_gain); end
            default: w_mul_state = 1'b0;
        endcase
        w_req.start = w_mul_state && !r_issued && !(r_state == S_POW && r_k == r_n);
        n_issued    = w_done ? 1'b0 : (r_issued | w_req.start);
        o_s_axis_tready = (r_state == S_IDLE);
    end

    // datapath
    logic signed [AW-1:0] w_coll, w_delta, w_np, w_mu, w_ms;
    always_comb begin
        w_coll = ONE_W - AW'(r_qn) - w_rnd;
        if (w_coll < 0) w_coll = '0;
        w_ms    = AW'(r_max_step);
        w_delta = w_rnd;
        if (w_delta > w_ms) w_delta = w_ms;
        if (w_delta < -w_ms) w_delta = -w_ms;
        // sum may go negative: compare signed
        w_np = AW'(r_p) + w_delta;
        if (w_np > $signed(AW'(r_max_prob))) w_np = AW'(r_max_prob);
        if (w_np < $signed(AW'(r_min_prob))) w_np = AW'(r_min_prob);
        w_mu = AW'(r_lagrange) + w_rnd;
        if (w_mu < 0) w_mu = '0;
        if (w_mu > AW'(33'h0FFFFFFFF)) w_mu = AW'(33'h0FFFFFFFF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_issued   <= 1'b0;
            r_o_valid  <= 1'b0;
            r_lagrange <= '0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            if (r_state == S_WB && (!r_o_valid || i_m_axis_tready)) begin
                r_o_valid  <= 1'b1;
                r_lagrange <= r_mu;
            end else if (r_o_valid && i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
        // item capture
        if (r_state == S_IDLE && i_s_axis_tvalid) begin
            r_p  <= w_p;
            r_q  <= w_q;
            r_n  <= w_n;
            r_k  <= '0;
            r_pw <= ONE;
        end
        // power chain: keep q^(n-2), q^(n-1), q^n on the way
        if (r_state == S_POW && !r_issued) begin
            if (r_k + NW'(2) == r_n) r_qn2 <= r_pw;
            if (r_k + NW'(1) == r_n) r_qn1 <= r_pw;
            if (r_k == r_n) r_qn <= r_pw;
        end
        if (w_done) begin
            case (r_state)
                S_POW: begin
                    r_pw <= w_rnd[PW-1:0];
                    r_k  <= r_k + NW'(1);
                end
                S_NP:   r_np_raw <= w_prod[22:0];
                S_SUCC: begin
                    r_coll <= w_coll[PW-1:0];
                    r_gap  <= 18'(w_coll) - 18'(r_budget);
                    r_ds   <= 32'(ONE);
                    r_dc   <= '0;
                end
                S_DS1:  r_t  <= w_rnd;
                S_DS2:  r_ds <= w_prod[31:0];
                S_DC1:  r_t  <= w_rnd;
                S_DC2:  r_t  <= w_prod;
                S_DC3:  r_dc <= w_prod[31:0];
                S_MH:   r_t  <= w_prod;
                S_ML:   r_grad <= sat_grad(AW'(r_ds) - r_t - w_rnd);
                S_DEL:  r_newp <= w_np[PW-1:0];
                S_MU:   r_mu <= w_mu[31:0];
                default: ;
            endcase
        end
        if (r_state == S_GRAD && !(r_gap > 0)) r_grad <= sat_grad(AW'(r_ds));
        if (r_state == S_WB && (!r_o_valid || i_m_axis_tready))
            r_o_data <= {6'd0, r_coll, r_mu, r_newp};
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

    // checks
    `CB_ASSERT_NXT(a_accept_busy, i_s_axis_tvalid && o_s_axis_tready, r_state != S_IDLE,
        "item accepted but sequencer stayed idle")
    `CB_ASSERT_NXT(a_mult_hold, r_state != S_WB, $stable(r_lagrange),
        "multiplier state changed outside write-back")
    `CB_ASSERT_IMP(a_done_issued, w_done, r_issued,
        "multiplier finished without a request")

endmodule
